@@ rtl/spjq_pkg.sv @@
package spjq_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int ID_W  = 16;
	localparam int PRI_W = 32;

	localparam logic [2:0] CMD_ADD    = 3'd0;
	localparam logic [2:0] CMD_FINISH = 3'd1;
	localparam logic [2:0] CMD_SORT   = 3'd2;
	localparam logic [2:0] CMD_CLEAR  = 3'd3;
	localparam logic [2:0] CMD_DUMP   = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic signed [PRI_W-1:0] pri;
		logic [ID_W-1:0]         id;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic sort_step;
		logic emit_head;
		logic emit_dump;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_sort;
		logic in_dump;
		logic empty;
		logic sort_done;
		logic dump_last;
		logic out_free;
	} dp_stat_t;

	// true when job a must come before job b
	function automatic logic goes_before(input entry_t a, input entry_t b);
		logic res;
		if (a.pri != b.pri) begin
			res = (a.pri > b.pri);
		end else begin
			res = (a.id < b.id);
		end
		return res;
	endfunction

endpackage

@@ rtl/sortable_priority_job_queue_top.sv @@
// Bounded job queue with in-place priority sort.
// Input channel (in_valid/in_ready) takes one command word: cmd and
// job_priority (used by add only). Output channel (out_valid/out_ready)
// gives result words: status, job_count, head or dumped entry, last.
// Add, finish, clear, sort and unused codes give one word with the head
// entry; dump gives one word per held job, or a single empty word.
// Timing: in_ready is high only while the controller idles. A command is
// taken in the idle state, and its head word is loaded into the output
// register from the head state once that register is free. Sort runs DEPTH
// odd-even transposition rounds in the slot registers, one per cycle.
// Dump reads one slot per cycle while the output register is free. The
// output register is the only buffer: a new command is taken while a word
// waits there, and the controller holds in its result state while the
// receiver stalls.
// Reset empties the queue and clears the id counter; no output word is
// pending after reset.
module sortable_priority_job_queue_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [2:0]                        cmd,
	input  logic signed [spjq_pkg::PRI_W-1:0] job_priority,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        status,
	output logic [spjq_pkg::CNT_W-1:0]        job_count,
	output logic                              entry_valid,
	output logic [spjq_pkg::ID_W-1:0]         entry_id,
	output logic signed [spjq_pkg::PRI_W-1:0] entry_priority,
	output logic                              last
);
	import spjq_pkg::*;

	dp_cmd_t  ctl;
	dp_stat_t stat;

	spjq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd_o    (ctl)
	);

	spjq_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.job_priority   (job_priority),
		.ctl            (ctl),
		.stat           (stat),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.job_count      (job_count),
		.entry_valid    (entry_valid),
		.entry_id       (entry_id),
		.entry_priority (entry_priority),
		.last           (last)
	);

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted a second command back to back");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> job_count <= CNT_W'(DEPTH))
		else $error("job count above depth");

	a_empty_entry_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !entry_valid |-> entry_id == '0 && entry_priority == '0)
		else $error("invalid entry carries data");

	a_one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.take, ctl.sort_step, ctl.emit_head, ctl.emit_dump}))
		else $error("controller issued two commands at once");

endmodule

@@ rtl/spjq_ctrl.sv @@
module spjq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  spjq_pkg::dp_stat_t stat,
	output spjq_pkg::dp_cmd_t  cmd_o
);
	import spjq_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SORT = 4'b0010,
		S_HEAD = 4'b0100,
		S_DUMP = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d         = state_q;
		in_ready        = 1'b0;
		cmd_o           = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd_o.take = 1'b1;
					if (stat.in_sort) begin
						state_d = S_SORT;
					end else if (stat.in_dump && !stat.empty) begin
						state_d = S_DUMP;
					end else begin
						state_d = S_HEAD;
					end
				end
			end
			S_SORT: begin
				cmd_o.sort_step = 1'b1;
				if (stat.sort_done) begin
					state_d = S_HEAD;
				end
			end
			S_HEAD: begin
				if (stat.out_free) begin
					cmd_o.emit_head = 1'b1;
					state_d         = S_IDLE;
				end
			end
			S_DUMP: begin
				if (stat.out_free) begin
					cmd_o.emit_dump = 1'b1;
					if (stat.dump_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/spjq_dpath.sv @@
module spjq_dpath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [2:0]                        cmd,
	input  logic signed [spjq_pkg::PRI_W-1:0] job_priority,
	input  spjq_pkg::dp_cmd_t                 ctl,
	output spjq_pkg::dp_stat_t                stat,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        status,
	output logic [spjq_pkg::CNT_W-1:0]        job_count,
	output logic                              entry_valid,
	output logic [spjq_pkg::ID_W-1:0]         entry_id,
	output logic signed [spjq_pkg::PRI_W-1:0] entry_priority,
	output logic                              last
);
	import spjq_pkg::*;

	entry_t            slot_q [DEPTH];
	entry_t            slot_srt [DEPTH];
	logic [CNT_W-1:0]  count_q;
	logic [ID_W-1:0]   id_ctr_q;
	logic [IDX_W-1:0]  round_q;
	logic [IDX_W-1:0]  dump_idx_q;
	logic [1:0]        op_status_q;
	logic              full;
	logic              empty;
	logic              dump_last;
	entry_t            dump_ent;

	logic              out_valid_q;
	logic [1:0]        out_status_q;
	logic [CNT_W-1:0]  out_count_q;
	logic              out_ev_q;
	entry_t            out_ent_q;
	logic              out_last_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign dump_last = ((CNT_W'(dump_idx_q) + CNT_W'(1)) == count_q);
	assign dump_ent  = slot_q[dump_idx_q];

	assign stat.in_sort   = (cmd == CMD_SORT);
	assign stat.in_dump   = (cmd == CMD_DUMP);
	assign stat.empty     = empty;
	assign stat.sort_done = (round_q == IDX_W'(DEPTH - 1));
	assign stat.dump_last = dump_last;
	assign stat.out_free  = !out_valid_q || out_ready;

	// one odd-even transposition round; pairs past the fill are left alone
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			slot_srt[i] = slot_q[i];
		end
		for (int i = 0; i < DEPTH - 1; i++) begin
			if (((i % 2) == int'(round_q[0])) && (CNT_W'(i + 1) < count_q)
			    && goes_before(slot_q[i+1], slot_q[i])) begin
				slot_srt[i]   = slot_q[i+1];
				slot_srt[i+1] = slot_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			if (cmd == CMD_ADD && !full) begin
				slot_q[count_q[IDX_W-1:0]] <= '{pri: job_priority, id: id_ctr_q};
			end else if (cmd == CMD_FINISH && !empty) begin
				for (int i = 0; i < DEPTH - 1; i++) begin
					slot_q[i] <= slot_q[i+1];
				end
			end
		end else if (ctl.sort_step) begin
			for (int i = 0; i < DEPTH; i++) begin
				slot_q[i] <= slot_srt[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			id_ctr_q    <= '0;
			round_q     <= '0;
			dump_idx_q  <= '0;
			op_status_q <= ST_OK;
		end else begin
			if (ctl.take) begin
				round_q    <= '0;
				dump_idx_q <= '0;
				case (cmd)
					CMD_ADD: begin
						if (full) begin
							op_status_q <= ST_FULL;
						end else begin
							op_status_q <= ST_OK;
							count_q     <= count_q + CNT_W'(1);
							id_ctr_q    <= id_ctr_q + ID_W'(1);
						end
					end
					CMD_FINISH: begin
						if (empty) begin
							op_status_q <= ST_EMPTY;
						end else begin
							op_status_q <= ST_OK;
							count_q     <= count_q - CNT_W'(1);
						end
					end
					CMD_CLEAR: begin
						op_status_q <= ST_OK;
						count_q     <= '0;
					end
					CMD_DUMP: begin
						op_status_q <= empty ? ST_EMPTY : ST_OK;
					end
					default: begin
						op_status_q <= ST_OK;
					end
				endcase
			end
			if (ctl.sort_step) begin
				round_q <= round_q + IDX_W'(1);
			end
			if (ctl.emit_dump) begin
				dump_idx_q <= dump_idx_q + IDX_W'(1);
			end
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit_head || ctl.emit_dump) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit_head) begin
			out_status_q <= op_status_q;
			out_count_q  <= count_q;
			out_ev_q     <= !empty;
			out_ent_q    <= empty ? '0 : slot_q[0];
			out_last_q   <= 1'b1;
		end else if (ctl.emit_dump) begin
			out_status_q <= op_status_q;
			out_count_q  <= count_q;
			out_ev_q     <= 1'b1;
			out_ent_q    <= dump_ent;
			out_last_q   <= dump_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign job_count      = out_count_q;
	assign entry_valid    = out_ev_q;
	assign entry_id       = out_ent_q.id;
	assign entry_priority = out_ent_q.pri;
	assign last           = out_last_q;

endmodule
